// ----- hdl/ssv_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ssv_pkg
// Shared types, constants and the byte-wide CRC-32 step of the shape-section
// stream validator.
// -----------------------------------------------------------------------------
package ssv_pkg;

    localparam int MAX_TARGETS = 256;
    localparam int TBL_AW      = $clog2(MAX_TARGETS);
    localparam int IDX_W       = TBL_AW + 1;
    localparam int HDR_WORDS   = 12;

    localparam logic [31:0] HEADER_SIZE        = 32'd48;
    localparam logic [31:0] HEADER_CRC_SPAN    = 32'd44;
    localparam logic [15:0] TARGET_RECORD_SIZE = 16'd8;
    localparam logic [15:0] DELTA_RECORD_SIZE  = 16'd28;
    localparam logic [31:0] CRC_POLY           = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT           = 32'hFFFF_FFFF;
    // Largest counts (and payload size) whose byte totals still fit in 32 bits.
    localparam logic [31:0] TC_LIMIT = 32'hFFFF_FFFF / 32'd8;
    localparam logic [31:0] DC_LIMIT = 32'hFFFF_FFFF / 32'd28;
    localparam logic [32:0] PAY_LIMIT = 33'h0_FFFF_FFFF - 33'd48;

    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    typedef enum logic [1:0] {
        ST_WELL_FORMED = 2'd0,
        ST_MALFORMED   = 2'd1,
        ST_OVERFLOW    = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] targets;
        logic [31:0] deltas;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/ssv_table_ram.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ssv_table_ram
// Target length table: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module ssv_table_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ssv_pkg::TBL_AW-1:0] i_waddr,
    input  wire logic [31:0]                i_wdata,
    input  wire logic [ssv_pkg::TBL_AW-1:0] i_raddr,
    output logic      [31:0]                o_rdata
);

    logic [31:0] mem [ssv_pkg::MAX_TARGETS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/ssv_out_buf.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ssv_out_buf
// Result register with one skid entry behind it.
// -----------------------------------------------------------------------------
module ssv_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ssv_pkg::t_result i_res,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output ssv_pkg::t_result      o_res
);

    logic             r_out_valid;
    logic             r_skid_valid;
    ssv_pkg::t_result r_out;
    ssv_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_out_valid && r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out       <= i_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/shape_section_stream_validator_unit.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// shape_section_stream_validator_unit
// Byte-serial validator of a shape-section blob with one result per blob.
// -----------------------------------------------------------------------------
// The block takes blob bytes and gives one result transaction when the byte
// marked last is taken. All checks on a byte are done in the cycle that byte is
// accepted, so an unstalled input runs at one byte per cycle with no gap
// between blobs. Target lengths go into a 256-entry synchronous table memory
// while target records stream in, and are read back ahead of each delta
// record; the read address only moves at the start of a delta record, so the
// registered read is always in time. Results land in an output register backed
// by one skid entry; the input is stalled only when both hold a result that
// downstream has not yet taken. Configuration (magic and version) goes through
// a separate always-ready port; the user must write it only while no blob is in
// flight; the block does not enforce it. No clearing pass is needed after reset.
// -----------------------------------------------------------------------------
module shape_section_stream_validator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status_code,
    output logic [31:0]      o_targets_found,
    output logic [31:0]      o_deltas_found
);

    // Configuration registers.
    logic [31:0] r_magic;
    logic [15:0] r_version;

    // Stream state.
    logic [31:0]               r_crc,  n_crc;
    logic [31:0]               r_pos,  n_pos;
    logic [31:0]               r_wa,   n_wa;
    logic [31:0]               r_hw [ssv_pkg::HDR_WORDS];
    logic [31:0]               r_sum,  n_sum;
    logic [ssv_pkg::IDX_W-1:0] r_idx,  n_idx;
    logic [31:0]               r_left, n_left;
    logic [15:0]               r_prev, n_prev;
    logic                      r_mal,  n_mal;
    logic                      r_ovf,  n_ovf;
    logic [4:0]                r_doff, n_doff;

    logic                        accept;
    logic                        hw_we;
    logic [3:0]                  hw_sel;
    logic                        tbl_we;
    logic [ssv_pkg::TBL_AW-1:0]  tbl_waddr;
    logic [31:0]                 tbl_rdata;
    logic                        buf_full;
    ssv_pkg::t_result            res;
    ssv_pkg::t_result            out_res;

    // Combinational scratch.
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] left_ld;
    logic        first;
    logic        bad;
    logic [32:0] pay;
    logic [31:0] dc28;
    ssv_pkg::t_status st;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid && !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= 32'd0;
            r_version <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ssv_pkg::CFG_MAGIC:   r_magic   <= i_cfg_data;
                ssv_pkg::CFG_VERSION: r_version <= i_cfg_data[15:0];
                default:              r_magic   <= r_magic;
            endcase
        end
    end

    assign hw_we  = (r_pos < ssv_pkg::HEADER_SIZE) && (r_pos[1:0] == 2'b11);
    assign hw_sel = r_pos[5:2];

    always_comb begin
        n_crc     = r_crc;
        n_pos     = r_pos;
        n_wa      = {i_data_byte, r_wa[31:8]};
        n_sum     = r_sum;
        n_idx     = r_idx;
        n_left    = r_left;
        n_prev    = r_prev;
        n_mal     = r_mal;
        n_ovf     = r_ovf;
        n_doff    = 5'd0;
        tbl_we    = 1'b0;
        tbl_waddr = '0;
        q         = r_pos - ssv_pkg::HEADER_SIZE;
        rem       = r_hw[4] - r_sum;
        first     = (r_left == 32'd0);
        left_ld   = r_left;
        bad       = 1'b0;
        pay       = {1'b0, r_hw[6]} + {1'b0, r_hw[7]};
        dc28      = (r_hw[4] << 5) - (r_hw[4] << 2);
        st        = ssv_pkg::ST_WELL_FORMED;

        if (r_pos < ssv_pkg::HEADER_CRC_SPAN || r_pos >= ssv_pkg::HEADER_SIZE) begin
            n_crc = ssv_pkg::crc_byte(r_crc, i_data_byte);
        end

        // Header checks on the last header byte; word 11 arrives this cycle.
        if (r_pos == ssv_pkg::HEADER_SIZE - 32'd1) begin
            bad = (r_hw[0] != r_magic) || (r_hw[1][15:0] != r_version)
                || (r_hw[1][31:16] != ssv_pkg::HEADER_SIZE[15:0])
                || (r_hw[5][15:0] != ssv_pkg::TARGET_RECORD_SIZE)
                || (r_hw[5][31:16] != ssv_pkg::DELTA_RECORD_SIZE)
                || (r_hw[9] != 32'd0) || (r_hw[10] != 32'd0)
                || (n_wa != ~r_crc)
                || (r_hw[3] == 32'd0) || (r_hw[4] == 32'd0)
                || (r_hw[3] > ssv_pkg::TC_LIMIT) || (r_hw[4] > ssv_pkg::DC_LIMIT)
                || (r_hw[6] != (r_hw[3] << 3)) || (r_hw[7] != dc28)
                || (pay > ssv_pkg::PAY_LIMIT)
                || (({1'b0, pay} + 34'd48) != {2'b00, r_hw[2]});
            if (bad) begin
                n_mal = 1'b1;
            end
            if (r_hw[3] > 32'(ssv_pkg::MAX_TARGETS)) begin
                n_ovf = 1'b1;
            end
            n_crc = ssv_pkg::CRC_INIT;
        end

        // Delta record byte offset runs whenever the target section is done.
        if (r_pos >= ssv_pkg::HEADER_SIZE && q >= r_hw[6]) begin
            n_doff = (r_doff == 5'(ssv_pkg::DELTA_RECORD_SIZE - 16'd1)) ? 5'd0 : r_doff + 5'd1;
        end

        if (r_pos >= ssv_pkg::HEADER_SIZE && !r_mal) begin
            if (r_pos >= r_hw[2]) begin
                n_mal = 1'b1;
            end else if (q < r_hw[6]) begin
                if (q[2:0] == 3'd3 && n_wa != r_sum) begin
                    n_mal = 1'b1;
                end
                if (q[2:0] == 3'd7) begin
                    if (n_wa == 32'd0 || n_wa > rem) begin
                        n_mal = 1'b1;
                    end else begin
                        n_sum = r_sum + n_wa;
                        if (q[31:3] < 29'(ssv_pkg::MAX_TARGETS)) begin
                            tbl_we    = 1'b1;
                            tbl_waddr = q[ssv_pkg::TBL_AW+2:3];
                        end
                        if (q == r_hw[6] - 32'd1) begin
                            // Lengths must add up to the delta count exactly.
                            if (n_wa != rem) begin
                                n_mal = 1'b1;
                            end
                            n_idx  = '0;
                            n_left = 32'd0;
                        end
                    end
                end
            end else if (r_doff[1:0] == 2'b11) begin
                if (r_doff == 5'd3) begin
                    if (n_wa[31:16] != 16'd0) begin
                        n_mal = 1'b1;
                    end
                    if (!r_ovf) begin
                        if (first) begin
                            left_ld = (r_idx < ssv_pkg::IDX_W'(ssv_pkg::MAX_TARGETS))
                                ? tbl_rdata : 32'd0;
                            n_idx   = r_idx + 1'b1;
                        end
                        if (!first && n_wa[15:0] <= r_prev) begin
                            n_mal = 1'b1;
                        end
                        n_prev = n_wa[15:0];
                        n_left = (left_ld != 32'd0) ? left_ld - 32'd1 : 32'd0;
                    end
                end else if (n_wa[30:23] == 8'hFF) begin
                    n_mal = 1'b1;
                end
            end
        end

        if (i_last_byte) begin
            if (r_pos < ssv_pkg::HEADER_SIZE - 32'd1) begin
                n_mal = 1'b1;
            end
            if (({1'b0, r_pos} + 33'd1) != {1'b0, r_hw[2]}) begin
                n_mal = 1'b1;
            end
            if (r_pos >= ssv_pkg::HEADER_SIZE && ~n_crc != r_hw[8]) begin
                n_mal = 1'b1;
            end
            st = n_mal ? ssv_pkg::ST_MALFORMED
               : (n_ovf ? ssv_pkg::ST_OVERFLOW : ssv_pkg::ST_WELL_FORMED);
            // Stream state returns to its reset values for the next blob.
            n_crc  = ssv_pkg::CRC_INIT;
            n_pos  = 32'd0;
            n_wa   = 32'd0;
            n_sum  = 32'd0;
            n_idx  = '0;
            n_left = 32'd0;
            n_prev = 16'd0;
            n_mal  = 1'b0;
            n_ovf  = 1'b0;
            n_doff = 5'd0;
        end else if (r_pos != 32'hFFFF_FFFF) begin
            n_pos = r_pos + 32'd1;
        end
    end

    assign res.status  = st;
    assign res.targets = (st == ssv_pkg::ST_MALFORMED) ? 32'd0 : r_hw[3];
    assign res.deltas  = (st == ssv_pkg::ST_MALFORMED) ? 32'd0 : r_hw[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= ssv_pkg::CRC_INIT;
            r_pos  <= 32'd0;
            r_wa   <= 32'd0;
            r_sum  <= 32'd0;
            r_idx  <= '0;
            r_left <= 32'd0;
            r_prev <= 16'd0;
            r_mal  <= 1'b0;
            r_ovf  <= 1'b0;
            r_doff <= 5'd0;
        end else if (accept) begin
            r_crc  <= n_crc;
            r_pos  <= n_pos;
            r_wa   <= n_wa;
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_left <= n_left;
            r_prev <= n_prev;
            r_mal  <= n_mal;
            r_ovf  <= n_ovf;
            r_doff <= n_doff;
        end
    end

    // Header words are payload: every word is rewritten before it is used.
    always_ff @(posedge i_clk) begin
        if (accept && hw_we) begin
            r_hw[hw_sel] <= {i_data_byte, r_wa[31:8]};
        end
    end

    ssv_table_ram u_table (
        .i_clk   (i_clk),
        .i_we    (accept && tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (n_wa),
        .i_raddr (r_idx[ssv_pkg::TBL_AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    ssv_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && i_last_byte),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_status_code   = out_res.status;
    assign o_targets_found = out_res.targets;
    assign o_deltas_found  = out_res.deltas;

    // A malformed result never carries counts.
    a_mal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_code == ssv_pkg::ST_MALFORMED
        |-> o_targets_found == 32'd0 && o_deltas_found == 32'd0)
        else $error("malformed result carries counts");

    // The input is held back only while a result is waiting downstream.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

    // A blob always starts over at byte zero after its last byte.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_pos == 32'd0 && !r_mal && !r_ovf)
        else $error("stream state not cleared after last byte");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Shape-section stream validator testbench
// Streams section blobs into the validator one byte per transaction. Each
// accepted byte is fed to a cycle-free model of the validator held in a
// small scoreboard class, which queues the verdict expected at every last
// byte. Verdict transactions from the block are compared field by field
// against that queue. Blobs are mostly well formed with random content; the rest
// carry single flaws, byte flips, truncations, extra bytes, random magic or noise.
// -----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 1750;
    localparam int MIN_VERDICTS = 48;

    // Deliberate defects that the blob builder can plant; all but FL_BAD_HDR_CRC
    // keep both CRC fields consistent, so only the targeted check fires.
    typedef enum int {
        FL_NONE,
        FL_INF_FLOAT,
        FL_RESERVED,
        FL_VERTEX_ORDER,
        FL_BAD_HDR_CRC
    } t_flaw;

    // -------------------------------------------------------------------------
    // Model of the validator and store of the verdicts it predicts.
    // -------------------------------------------------------------------------
    class verdict_board;
        bit [31:0] magic_reg;
        bit [15:0] version_reg;

        bit [31:0] crc;
        bit [31:0] pos;
        bit [31:0] word;
        bit [31:0] hw [ssv_pkg::HDR_WORDS];
        bit [31:0] tlen [ssv_pkg::MAX_TARGETS];
        bit [31:0] dsum;
        int unsigned tidx;
        bit [31:0] dleft;
        bit [15:0] prev_v;
        bit        bad;
        bit        ovf;

        ssv_pkg::t_result verdicts [$];
        int errors;
        int checked;
        int n_ok, n_bad, n_ovf;

        function new();
            magic_reg   = '0;
            version_reg = '0;
            foreach (tlen[i]) tlen[i] = '0;
            errors  = 0;
            checked = 0;
            n_ok = 0;
            n_bad = 0;
            n_ovf = 0;
            clear_stream();
        endfunction

        static function bit [31:0] crc_step(bit [31:0] c, bit [7:0] b);
            bit [31:0] r;
            r = c ^ {24'd0, b};
            repeat (8) r = (r >> 1) ^ (r[0] ? 32'hEDB8_8320 : 32'd0);
            return r;
        endfunction

        function void clear_stream();
            crc  = '1;
            pos  = '0;
            word = '0;
            foreach (hw[i]) hw[i] = '0;
            dsum   = '0;
            tidx   = 0;
            dleft  = '0;
            prev_v = '0;
            bad    = 1'b0;
            ovf    = 1'b0;
        endfunction

        function void check_header();
            bit [31:0] tc, dc, tb_, db;
            longint unsigned pay;
            bit h;
            tc  = hw[3];
            dc  = hw[4];
            tb_ = hw[6];
            db  = hw[7];
            pay = longint'(tb_) + longint'(db);
            h = 1'b0;
            h |= hw[0] != magic_reg;
            h |= hw[1][15:0] != version_reg;
            h |= hw[1][31:16] != 16'd48;
            h |= hw[5][15:0] != 16'd8;
            h |= hw[5][31:16] != 16'd28;
            h |= hw[9] != 0 || hw[10] != 0;
            h |= hw[11] != ~crc;
            h |= tc == 0 || dc == 0;
            h |= tc > 32'hFFFF_FFFF / 32'd8;
            h |= dc > 32'hFFFF_FFFF / 32'd28;
            if (!h) begin
                h |= tb_ != tc * 32'd8;
                h |= db != dc * 32'd28;
            end
            h |= pay > 64'hFFFF_FFFF - 64'd48;
            h |= pay + 64'd48 != longint'(hw[2]);
            if (h) bad = 1'b1;
            if (tc > ssv_pkg::MAX_TARGETS) ovf = 1'b1;
        endfunction

        function void check_payload(bit [31:0] p);
            bit [31:0] q, o, t, tb_, dc;
            bit first;
            q   = p - 32'd48;
            tb_ = hw[6];
            dc  = hw[4];
            if (p >= hw[2]) begin
                bad = 1'b1;
                return;
            end
            if (q < tb_) begin
                o = q % 8;
                t = q / 8;
                if (o == 3 && word != dsum) bad = 1'b1;
                if (o == 7) begin
                    if (word == 0 || word > dc - dsum) begin
                        bad = 1'b1;
                        return;
                    end
                    dsum += word;
                    if (t < ssv_pkg::MAX_TARGETS) tlen[t] = word;
                    if (q == tb_ - 1) begin
                        if (dsum != dc) bad = 1'b1;
                        tidx  = 0;
                        dleft = '0;
                    end
                end
            end else begin
                o = (q - tb_) % 28;
                if (o[1:0] != 2'd3) return;
                if (o == 3) begin
                    first = 1'b0;
                    if (word[31:16] != 0) bad = 1'b1;
                    if (!ovf) begin
                        if (dleft == 0) begin
                            if (tidx < ssv_pkg::MAX_TARGETS) dleft = tlen[tidx];
                            tidx++;
                            first = 1'b1;
                        end
                        if (!first && word[15:0] <= prev_v) bad = 1'b1;
                        prev_v = word[15:0];
                        if (dleft > 0) dleft--;
                    end
                end else if (word[30:23] == 8'hFF) begin
                    bad = 1'b1;
                end
            end
        endfunction

        // Notes one accepted byte; a last byte queues the verdict.
        function void take_byte(bit [7:0] b, bit last);
            bit [31:0] p;
            ssv_pkg::t_result v;
            p = pos;
            word = {b, word[31:8]};
            if (p < 44 || p >= 48) crc = crc_step(crc, b);
            if (p < 48 && p[1:0] == 2'd3) hw[(p >> 2) % ssv_pkg::HDR_WORDS] = word;
            if (p == 47) begin
                check_header();
                crc = '1;
            end
            if (p >= 48 && !bad) check_payload(p);
            if (!last) begin
                if (pos != 32'hFFFF_FFFF) pos++;
                return;
            end
            if (p < 47) bad = 1'b1;
            if (longint'(p) + 1 != longint'(hw[2])) bad = 1'b1;
            if (p >= 48 && ~crc != hw[8]) bad = 1'b1;
            v.status  = bad ? ssv_pkg::ST_MALFORMED
                      : (ovf ? ssv_pkg::ST_OVERFLOW : ssv_pkg::ST_WELL_FORMED);
            v.targets = bad ? 32'd0 : hw[3];
            v.deltas  = bad ? 32'd0 : hw[4];
            verdicts.push_back(v);
            clear_stream();
        endfunction

        function void compare_verdict(ssv_pkg::t_status s, bit [31:0] t, bit [31:0] d);
            ssv_pkg::t_result e;
            checked++;
            if (verdicts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: verdict with none pending: status %0d t %0d d %0d",
                             s, t, d);
                return;
            end
            e = verdicts.pop_front();
            case (e.status)
                ssv_pkg::ST_WELL_FORMED: n_ok++;
                ssv_pkg::ST_MALFORMED:   n_bad++;
                default:                 n_ovf++;
            endcase
            if (e.status != s || e.targets != t || e.deltas != d) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: verdict %0d exp status %0d t %0d d %0d, got %0d t %0d d %0d",
                             checked, e.status, e.targets, e.deltas, s, t, d);
            end
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset and DUT
    // -------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status_code;
    logic [31:0] o_targets_found;
    logic [31:0] o_deltas_found;

    verdict_board board;
    int cycles;
    int bytes_sent;
    int blobs_sent;
    bit burst_mode;     // when set, the sender offers bytes back to back
    bit hold_req;       // asks the receiver for one long hold-off
    int rx_pct;

    shape_section_stream_validator_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status_code   (o_status_code),
        .o_targets_found (o_targets_found),
        .o_deltas_found  (o_deltas_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: the slowest correct run is far below this limit.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d verdicts pending.",
                     cycles, board.verdicts.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Verdict transactions are checked at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.compare_verdict(ssv_pkg::t_status'(o_status_code), o_targets_found,
                                  o_deltas_found);
    end

    // -------------------------------------------------------------------------
    // Receiver: random back-pressure whose density changes over time, short
    // and occasional long stall runs, and one long hold-off on request.
    // -------------------------------------------------------------------------
    initial begin
        int run_left;
        int hold_left;
        int pct_left;
        i_out_stall = 1'b0;
        run_left  = 0;
        hold_left = 0;
        pct_left  = 0;
        rx_pct    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (pct_left == 0) begin
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 20;
                    default: rx_pct = 50;
                endcase
                pct_left = $urandom_range(100, 400);
            end
            pct_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                i_out_stall = 1'b1;
            end else if (rx_pct != 0 && $urandom_range(0, 99) < 2) begin
                run_left = $urandom_range(10, 40);
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < rx_pct);
            end
        end
    end

    // -------------------------------------------------------------------------
    // Sender tasks
    // -------------------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ssv_pkg::CFG_MAGIC) board.magic_reg = data;
        else board.version_reg = data[15:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Offers one byte and waits until the block takes it. Valid stays high
    // into the next byte unless a gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        do @(posedge i_clk); while (o_in_stall);
        board.take_byte(b, last);
        bytes_sent++;
        if (!burst_mode) begin
            gap = $urandom_range(0, 99);
            if (gap < 70) gap = 0;
            else if (gap < 96) gap = $urandom_range(1, 3);
            else gap = $urandom_range(10, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_blob(input logic [7:0] q [$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
        blobs_sent++;
    endtask

    function automatic void put32(ref logic [7:0] q [$], input logic [31:0] w);
        for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
    endfunction

    // Builds a consistent blob: lens holds the delta count of each target.
    function automatic void build_blob(ref logic [7:0] q [$], input int lens [$],
                                       input logic [31:0] magic,
                                       input logic [15:0] ver, input t_flaw flaw);
        logic [7:0]  pl [$];
        logic [31:0] first, dc, f, pcrc, hcrc;
        logic [15:0] v;
        int k;
        q = {};
        first = 0;
        foreach (lens[t]) begin
            put32(pl, first);
            put32(pl, lens[t]);
            first += lens[t];
        end
        dc = first;
        k = 0;
        foreach (lens[t]) begin
            v = $urandom_range(0, 60);
            for (int j = 0; j < lens[t]; j++) begin
                put32(pl, {(flaw == FL_RESERVED && k == dc - 1) ? 16'h0100 : 16'h0000, v});
                for (int n = 0; n < 6; n++) begin
                    f = $urandom;
                    if (f[30:23] == 8'hFF) f[23] = 1'b0;
                    if (flaw == FL_INF_FLOAT && k == dc - 1 && n == 5)
                        f = {f[31], 8'hFF, f[22:0]};
                    put32(pl, f);
                end
                if (!(flaw == FL_VERTEX_ORDER && k == 0))
                    v += $urandom_range(1, 200);
                k++;
            end
        end
        pcrc = '1;
        foreach (pl[i]) pcrc = verdict_board::crc_step(pcrc, pl[i]);
        put32(q, magic);
        put32(q, {16'd48, ver});
        put32(q, 32'd48 + pl.size());
        put32(q, lens.size());
        put32(q, dc);
        put32(q, {16'd28, 16'd8});
        put32(q, lens.size() * 8);
        put32(q, dc * 28);
        put32(q, ~pcrc);
        put32(q, 32'd0);
        put32(q, 32'd0);
        hcrc = '1;
        foreach (q[i]) hcrc = verdict_board::crc_step(hcrc, q[i]);
        put32(q, (flaw == FL_BAD_HDR_CRC) ? hcrc : ~hcrc);
        foreach (pl[i]) q.push_back(pl[i]);
    endfunction

    function automatic void random_lens(ref int lens [$], input t_flaw flaw);
        lens = {};
        repeat ($urandom_range(1, 3)) lens.push_back($urandom_range(1, 4));
        if (flaw == FL_VERTEX_ORDER && lens[0] < 2) lens[0] = 2;
    endfunction

    function automatic void noise_blob(ref logic [7:0] q [$]);
        q = {};
        repeat ($urandom_range(1, 70)) q.push_back($urandom_range(0, 255));
    endfunction

    // One random blob: mostly well formed, the rest damaged in some way.
    task automatic random_blob();
        logic [7:0] q [$];
        int lens [$];
        int r, idx;
        t_flaw flaw;
        r = $urandom_range(0, 99);
        flaw = FL_NONE;
        if (r >= 55 && r < 62) flaw = t_flaw'($urandom_range(FL_INF_FLOAT, FL_BAD_HDR_CRC));
        random_lens(lens, flaw);
        build_blob(q, lens, board.magic_reg, board.version_reg, flaw);
        if (r >= 62 && r < 74) begin
            idx = $urandom_range(0, q.size() - 1);
            q[idx] = q[idx] ^ $urandom_range(1, 255);
        end else if (r >= 74 && r < 80) begin
            q = q[0 : $urandom_range(0, q.size() - 2)];
        end else if (r >= 80 && r < 85) begin
            repeat ($urandom_range(1, 4)) q.push_back($urandom_range(0, 255));
        end else if (r >= 85 && r < 90) begin
            build_blob(q, lens, $urandom, $urandom, FL_NONE);
        end else if (r >= 90) begin
            noise_blob(q);
        end
        burst_mode = ($urandom_range(0, 3) == 0);
        send_blob(q);
    endtask

    // Lets the block finish every pending verdict before a register write.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // -------------------------------------------------------------------------
    // Main sequence
    // -------------------------------------------------------------------------
    initial begin
        logic [7:0] q [$];
        int lens [$];
        logic [31:0] magics [4];
        logic [15:0] versions [4];

        board = new();
        bytes_sent  = 0;
        blobs_sent  = 0;
        burst_mode  = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ssv_pkg::CFG_MAGIC;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: the reset registers first, then the basic cases.
        lens = {1};
        build_blob(q, lens, 32'd0, 16'd0, FL_NONE);
        send_blob(q);
        q = {8'hA5};
        send_blob(q);                                       // one-byte blob
        q = {};
        repeat (47) q.push_back(8'h00);
        send_blob(q);                                       // header cut short
        build_blob(q, lens, 32'd0, 16'd0, FL_NONE);
        q.push_back(8'hFF);
        send_blob(q);                                       // byte past file size
        foreach (lens[i]) lens[i] = 2;
        build_blob(q, lens, 32'd0, 16'd0, FL_VERTEX_ORDER);
        send_blob(q);
        build_blob(q, lens, 32'd0, 16'd0, FL_INF_FLOAT);
        send_blob(q);
        build_blob(q, lens, 32'd0, 16'd0, FL_RESERVED);
        send_blob(q);
        build_blob(q, lens, 32'd0, 16'd0, FL_BAD_HDR_CRC);
        send_blob(q);
        build_blob(q, lens, 32'd1, 16'd0, FL_NONE);
        send_blob(q);                                       // wrong magic
        drain();

        // One blob with more targets than the table holds; vertex order is
        // not enforced there, so the random vertices are fine.
        write_reg(ssv_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(ssv_pkg::CFG_VERSION, 32'h0000_FFFF);
        lens = {};
        repeat (ssv_pkg::MAX_TARGETS + 1) lens.push_back(1);
        burst_mode = 1'b1;
        build_blob(q, lens, 32'hFFFF_FFFF, 16'hFFFF, FL_NONE);
        send_blob(q);
        burst_mode = 1'b0;

        // Random phases with changing register settings, extremes included.
        magics   = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h5345_4853, $urandom};
        versions = '{16'hFFFF, 16'h0001, 16'h0000, $urandom};
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_reg(ssv_pkg::CFG_MAGIC, magics[ph]);
            write_reg(ssv_pkg::CFG_VERSION, {16'd0, versions[ph]});
            if (ph == 1) begin
                // Hold the receiver off while short blobs keep coming, so the
                // result buffer fills and the input side has to stall.
                hold_req = 1'b1;
                burst_mode = 1'b1;
                repeat (8) begin
                    noise_blob(q);
                    send_blob(q);
                end
            end
            while (bytes_sent < (ph + 1) * RANDOM_BYTES / 4 ||
                   board.checked + board.verdicts.size() < (ph + 1) * MIN_VERDICTS / 4 + 10)
                random_blob();
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d blobs (%0d bytes) in %0d cycles under four register settings.",
                 blobs_sent, bytes_sent, cycles);
        $display("Verdicts checked: %0d well formed, %0d malformed, %0d table overflow.",
                 board.n_ok, board.n_bad, board.n_ovf);
        if (board.errors == 0 && board.verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d verdicts never arrived.",
                     board.errors, board.verdicts.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ssv_pkg.sv
hdl/ssv_table_ram.sv
hdl/ssv_out_buf.sv
hdl/shape_section_stream_validator_unit.sv
tb/tb.sv
